[src/sync_length_packet_deframer_assert.svh]
// ----------------------------------------------------------------------------
// sync length packet deframer assertion macros
// shared property forms for the deframer checks
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SLPD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define SLPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deframer check failed");

// next-cycle implication that also holds across reset
`define SLPD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

[src/slpd_pkg.sv]
// ----------------------------------------------------------------------------
// slpd_pkg
// types and constants of the sync length packet deframer
// ----------------------------------------------------------------------------
package slpd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SUM_W   = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_CHECKED   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_UNCHECKED = 1'd1;

    localparam logic [CFG_W-1:0] SYNC_CHECKED_RESET   = 16'hC1AF;
    localparam logic [CFG_W-1:0] SYNC_UNCHECKED_RESET = 16'hC1AE;

    typedef struct packed {
        logic              data_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] packet_type;
        logic [BYTE_W-1:0] byte_index;
        logic              last;
        logic              has_checksum;
        logic              checksum_ok;
    } result_t;

endpackage

[src/sync_length_packet_deframer.sv]
// output: each result word is registered, in the skid register while m_* stalls
// throughput: one input word per cycle unless the skid is full; results leave
// through an output and a skid register, so input flows while one result waits
// reset: aresetn synchronous active low, returns to sync hunt and restores the
// reset sync words; result registers come up empty
// ----------------------------------------------------------------------------
// sync_length_packet_deframer
// byte-serial deframer: sync word hunt, type, length, optional sum16
// checksum, then payload words (or an empty packet marker) with index, last flag and checksum status
// ----------------------------------------------------------------------------
module sync_length_packet_deframer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [slpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [slpd_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_rx_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_data_valid,
    output logic [7:0]                           m_payload_byte,
    output logic [7:0]                           m_packet_type,
    output logic [7:0]                           m_byte_index,
    output logic                                 m_last,
    output logic                                 m_has_checksum,
    output logic                                 m_checksum_ok
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LENGTH,
        PH_CS_LO,
        PH_CS_HI,
        PH_PAYLOAD
    } phase_t;

    localparam int unsigned BW = slpd_pkg::BYTE_W;
    localparam int unsigned SW = slpd_pkg::SUM_W;

    logic [slpd_pkg::CFG_W-1:0] sync_checked_reg;
    logic [slpd_pkg::CFG_W-1:0] sync_unchecked_reg;

    phase_t          phase_reg, phase_next;
    logic [BW-1:0]   prev_byte_reg, prev_byte_next;
    logic            checked_reg, checked_next;
    logic [BW-1:0]   type_reg, type_next;
    logic [BW-1:0]   length_reg, length_next;
    logic [BW-1:0]   seen_reg, seen_next;
    logic [SW-1:0]   rx_sum_reg, rx_sum_next;
    logic [SW-1:0]   run_sum_reg, run_sum_next;

    slpd_pkg::result_t res_next;
    logic              res_valid;

    slpd_pkg::result_t out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;

    logic            accept;
    logic [SW-1:0]   hunt_word;
    logic [SW-1:0]   sum_add;
    logic [SW-1:0]   cs_full;
    logic            is_last;

    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign hunt_word = {s_rx_byte, prev_byte_reg};
    assign sum_add   = run_sum_reg + {{(SW-BW){1'b0}}, s_rx_byte};
    assign cs_full   = {s_rx_byte, rx_sum_reg[BW-1:0]};
    assign is_last   = ({1'b0, seen_reg} + {{BW{1'b0}}, 1'b1}) == {1'b0, length_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_checked_reg   <= slpd_pkg::SYNC_CHECKED_RESET;
            sync_unchecked_reg <= slpd_pkg::SYNC_UNCHECKED_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                slpd_pkg::CFG_SYNC_CHECKED:   sync_checked_reg   <= cfg_data;
                slpd_pkg::CFG_SYNC_UNCHECKED: sync_unchecked_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // framing logic for one input word
    always_comb begin
        phase_next     = phase_reg;
        prev_byte_next = prev_byte_reg;
        checked_next   = checked_reg;
        type_next      = type_reg;
        length_next    = length_reg;
        seen_next      = seen_reg;
        rx_sum_next    = rx_sum_reg;
        run_sum_next   = run_sum_reg;
        res_valid      = 1'b0;
        res_next.data_valid   = 1'b0;
        res_next.payload_byte = '0;
        res_next.packet_type  = type_reg;
        res_next.byte_index   = '0;
        res_next.last         = 1'b1;
        res_next.has_checksum = checked_reg;
        res_next.checksum_ok  = 1'b1;

        case (phase_reg)
            PH_TYPE: begin
                type_next  = s_rx_byte;
                phase_next = PH_LENGTH;
            end
            PH_LENGTH: begin
                length_next  = s_rx_byte;
                seen_next    = '0;
                run_sum_next = '0;
                rx_sum_next  = '0;
                if (checked_reg) begin
                    phase_next = PH_CS_LO;
                end else if (s_rx_byte == '0) begin
                    // empty packet marker
                    res_valid      = 1'b1;
                    phase_next     = PH_HUNT;
                    prev_byte_next = '0;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_CS_LO: begin
                rx_sum_next = {{(SW-BW){1'b0}}, s_rx_byte};
                phase_next  = PH_CS_HI;
            end
            PH_CS_HI: begin
                rx_sum_next = cs_full;
                if (length_reg == '0) begin
                    // empty packet marker
                    res_valid            = 1'b1;
                    res_next.checksum_ok = (cs_full == '0);
                    phase_next           = PH_HUNT;
                    prev_byte_next       = '0;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                run_sum_next          = sum_add;
                res_valid             = 1'b1;
                res_next.data_valid   = 1'b1;
                res_next.payload_byte = s_rx_byte;
                res_next.byte_index   = seen_reg;
                res_next.last         = is_last;
                res_next.checksum_ok  = is_last && (!checked_reg || (sum_add == rx_sum_reg));
                if (is_last) begin
                    phase_next     = PH_HUNT;
                    prev_byte_next = '0;
                end else begin
                    seen_next = seen_reg + {{(BW-1){1'b0}}, 1'b1};
                end
            end
            default: begin
                prev_byte_next = s_rx_byte;
                phase_next     = PH_HUNT;
                if (hunt_word == sync_checked_reg) begin
                    checked_next = 1'b1;
                    phase_next   = PH_TYPE;
                end else if (hunt_word == sync_unchecked_reg) begin
                    checked_next = 1'b0;
                    phase_next   = PH_TYPE;
                end
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            prev_byte_reg  <= '0;
            checked_reg    <= 1'b0;
            type_reg       <= '0;
            length_reg     <= '0;
            seen_reg       <= '0;
            rx_sum_reg     <= '0;
            run_sum_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg     <= phase_next;
                prev_byte_reg <= prev_byte_next;
                checked_reg   <= checked_next;
                type_reg      <= type_next;
                length_reg    <= length_next;
                seen_reg      <= seen_next;
                rx_sum_reg    <= rx_sum_next;
                run_sum_reg   <= run_sum_next;
            end
            if (out_valid_reg && !m_ready) begin
                if (accept && res_valid) begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept && res_valid;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_ready) begin
            if (accept && res_valid) begin
                skid_reg <= res_next;
            end
        end else if (skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (accept && res_valid) begin
            out_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_data_valid   = out_reg.data_valid;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_packet_type  = out_reg.packet_type;
    assign m_byte_index   = out_reg.byte_index;
    assign m_last         = out_reg.last;
    assign m_has_checksum = out_reg.has_checksum;
    assign m_checksum_ok  = out_reg.checksum_ok;

endmodule

[src/slpd_checker.sv]
// ----------------------------------------------------------------------------
// slpd_checker
// port-level checks of the sync length packet deframer, bound to the top
// ----------------------------------------------------------------------------
`include "sync_length_packet_deframer_assert.svh"

module slpd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_data_valid,
    input logic [7:0] m_payload_byte,
    input logic [7:0] m_packet_type,
    input logic [7:0] m_byte_index,
    input logic       m_last,
    input logic       m_has_checksum,
    input logic       m_checksum_ok
);

    logic        out_stall;
    logic [27:0] out_word;
    logic        marker_shape;

    assign out_stall    = m_valid && !m_ready;
    assign out_word     = {m_data_valid, m_payload_byte, m_packet_type, m_byte_index,
                           m_last, m_has_checksum, m_checksum_ok};
    assign marker_shape = m_last && (m_byte_index == 8'd0) && (m_payload_byte == 8'd0);

    // a stalled result word holds
    `SLPD_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(out_word))

    // checksum status only on the final word of a packet
    `SLPD_ASSERT_NOW(a_ok_only_last, aclk, aresetn, m_valid && !m_last, !m_checksum_ok)

    // empty packet marker has zero byte and index and is last
    `SLPD_ASSERT_NOW(a_empty_marker, aclk, aresetn, m_valid && !m_data_valid, marker_shape)

    // result side comes out of reset empty
    `SLPD_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind sync_length_packet_deframer slpd_checker u_slpd_checker (.*);

[tb/tb_sync_length_packet_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_length_packet_deframer
// drives link bytes through the deframer under random sender gaps and
// receiver stalls; a behavioral deframer tracks sync hunt, header, checksum
// and payload and queues the word each byte should produce; directed frames
// come first, then random frames under several sync word settings
// ----------------------------------------------------------------------------
module tb_sync_length_packet_deframer;

    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int RAND_PHASES     = 6;
    localparam int WORDS_PER_PHASE = 200;

    typedef enum logic [2:0] {
        HUNT, GET_TYPE, GET_LEN, GET_SUM_LO, GET_SUM_HI, GET_PAYLOAD
    } deframe_phase_t;

    typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

    typedef enum logic [1:0] {RCV_OPEN, RCV_COIN, RCV_TICK, RCV_CHOKE} rcv_mode_t;

    typedef struct {
        row_kind_t                      kind;
        logic [7:0]                     rx;
        logic [slpd_pkg::CFG_IDX_W-1:0] idx;
        logic [slpd_pkg::CFG_W-1:0]     value;
        bit                             fixed;
        slpd_pkg::result_t              want;
    } stim_row_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [slpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [slpd_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_rx_byte = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic                           m_data_valid;
    logic [7:0]                     m_payload_byte;
    logic [7:0]                     m_packet_type;
    logic [7:0]                     m_byte_index;
    logic                           m_last;
    logic                           m_has_checksum;
    logic                           m_checksum_ok;

    // deframer model state
    deframe_phase_t ph         = HUNT;
    logic [7:0]     prev_rx    = '0;
    logic           chk_mode   = 1'b0;
    logic [7:0]     hdr_type   = '0;
    logic [7:0]     pay_len    = '0;
    logic [7:0]     seen       = '0;
    logic [15:0]    rx_sum     = '0;
    logic [15:0]    run_sum    = '0;
    logic [15:0]    sync_chk   = slpd_pkg::SYNC_CHECKED_RESET;
    logic [15:0]    sync_plain = slpd_pkg::SYNC_UNCHECKED_RESET;

    slpd_pkg::result_t pending_words[$];
    int                n_errors    = 0;
    int                n_sent      = 0;
    int                burst_left  = 0;
    int                idle_cycles = 0;
    int                rcv_cyc     = 0;
    rcv_mode_t         rcv_mode    = RCV_OPEN;

    sync_length_packet_deframer uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_valid   (m_data_valid),
        .m_payload_byte (m_payload_byte),
        .m_packet_type  (m_packet_type),
        .m_byte_index   (m_byte_index),
        .m_last         (m_last),
        .m_has_checksum (m_has_checksum),
        .m_checksum_ok  (m_checksum_ok)
    );

    always #1 aclk = ~aclk;

    function automatic slpd_pkg::result_t frame_word(input logic dv, input logic [7:0] pb,
                                                     input logic [7:0] pt,
                                                     input logic [7:0] idx,
                                                     input logic lst, input logic hc,
                                                     input logic ok);
        slpd_pkg::result_t r;
        r.data_valid   = dv;
        r.payload_byte = pb;
        r.packet_type  = pt;
        r.byte_index   = idx;
        r.last         = lst;
        r.has_checksum = hc;
        r.checksum_ok  = ok;
        return r;
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] b, input bit fixed = 1'b0,
                                           input slpd_pkg::result_t want = '0);
        stim_row_t row;
        row.kind  = ROW_BYTE;
        row.rx    = b;
        row.idx   = '0;
        row.value = '0;
        row.fixed = fixed;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [slpd_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [slpd_pkg::CFG_W-1:0] value);
        stim_row_t row;
        row       = byte_row(8'h00);
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.value = value;
        return row;
    endfunction

    // advances the model by one link byte, returns 1 when a word comes out
    function automatic bit deframe_byte(input logic [7:0] c, output slpd_pkg::result_t r);
        logic [15:0] word;
        logic        lst;
        r = '0;
        case (ph)
            GET_TYPE: begin
                hdr_type = c;
                ph = GET_LEN;
                return 1'b0;
            end
            GET_LEN: begin
                pay_len = c;
                seen    = '0;
                run_sum = '0;
                rx_sum  = '0;
                if (chk_mode) begin
                    ph = GET_SUM_LO;
                    return 1'b0;
                end
                if (c == 8'h00) begin
                    r = frame_word(1'b0, 8'h00, hdr_type, 8'h00, 1'b1, 1'b0, 1'b1);
                    ph = HUNT;
                    prev_rx = '0;
                    return 1'b1;
                end
                ph = GET_PAYLOAD;
                return 1'b0;
            end
            GET_SUM_LO: begin
                rx_sum = {8'h00, c};
                ph = GET_SUM_HI;
                return 1'b0;
            end
            GET_SUM_HI: begin
                rx_sum[15:8] = c;
                if (pay_len == 8'h00) begin
                    r = frame_word(1'b0, 8'h00, hdr_type, 8'h00, 1'b1, 1'b1, rx_sum == 16'h0000);
                    ph = HUNT;
                    prev_rx = '0;
                    return 1'b1;
                end
                ph = GET_PAYLOAD;
                return 1'b0;
            end
            GET_PAYLOAD: begin
                run_sum = run_sum + {8'h00, c};
                lst = ({1'b0, seen} + 9'd1) == {1'b0, pay_len};
                r = frame_word(1'b1, c, hdr_type, seen, lst, chk_mode,
                               lst && (!chk_mode || run_sum == rx_sum));
                if (lst) begin
                    ph = HUNT;
                    prev_rx = '0;
                end else begin
                    seen = seen + 8'd1;
                end
                return 1'b1;
            end
            default: begin
                word = {c, prev_rx};
                prev_rx = c;
                ph = HUNT;
                if (word == sync_chk) begin
                    chk_mode = 1'b1;
                    ph = GET_TYPE;
                end else if (word == sync_plain) begin
                    chk_mode = 1'b0;
                    ph = GET_TYPE;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function void check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endfunction

    task automatic push_word(input logic [7:0] b, input bit fixed = 1'b0,
                             input slpd_pkg::result_t want = '0);
        slpd_pkg::result_t r;
        bit                got;
        int                gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        n_sent++;
        got = deframe_byte(b, r);
        if (fixed) begin
            pending_words.push_back(want);
        end else if (got) begin
            pending_words.push_back(r);
        end
    endtask

    task automatic write_reg(input logic [slpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slpd_pkg::CFG_W-1:0] value);
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == slpd_pkg::CFG_SYNC_CHECKED) begin
            sync_chk = value;
        end else begin
            sync_plain = value;
        end
    endtask

    // receiver stall pattern, redrawn at random among the four receiver modes
    always @(posedge aclk) begin
        rcv_cyc++;
        if (rcv_cyc % 64 == 0) begin
            rcv_mode = rcv_mode_t'($urandom_range(0, 3));
        end
        case (rcv_mode)
            RCV_OPEN:  m_ready <= 1'b1;
            RCV_COIN:  m_ready <= 1'($urandom_range(0, 1));
            RCV_TICK:  m_ready <= (rcv_cyc % 5 != 0);
            default:   m_ready <= (rcv_cyc % 16 >= 12);
        endcase
    end

    always @(posedge aclk) begin : result_check
        slpd_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("result word with none expected");
                n_errors++;
            end else begin
                want = pending_words.pop_front();
                check_field("data_valid", 16'(want.data_valid), 16'(m_data_valid));
                check_field("payload_byte", 16'(want.payload_byte), 16'(m_payload_byte));
                check_field("packet_type", 16'(want.packet_type), 16'(m_packet_type));
                check_field("byte_index", 16'(want.byte_index), 16'(m_byte_index));
                check_field("last", 16'(want.last), 16'(m_last));
                check_field("has_checksum", 16'(want.has_checksum), 16'(m_has_checksum));
                check_field("checksum_ok", 16'(want.checksum_ok), 16'(m_checksum_ok));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t   rows[$];
        logic [7:0]  pay[$];
        logic [15:0] csum;
        logic [15:0] sw;
        logic [15:0] chk_val;
        logic [15:0] plain_val;
        int          len;
        int          pick;
        int          target;

        rows = '{
            // checked framing, empty packet, zero checksum
            byte_row(8'hAF), byte_row(8'hC1), byte_row(8'hFF), byte_row(8'h00),
            byte_row(8'h00),
            byte_row(8'h00, 1'b1, frame_word(1'b0, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1)),
            // checked framing, two bytes, wrong checksum
            byte_row(8'hAF), byte_row(8'hC1), byte_row(8'h80), byte_row(8'h02),
            byte_row(8'h00), byte_row(8'h00), byte_row(8'hFF),
            byte_row(8'h01, 1'b1, frame_word(1'b1, 8'h01, 8'h80, 8'h01, 1'b1, 1'b1, 1'b0)),
            // equal sync words, checked framing wins; empty with nonzero checksum
            reg_row(slpd_pkg::CFG_SYNC_CHECKED, 16'h1234),
            reg_row(slpd_pkg::CFG_SYNC_UNCHECKED, 16'h1234),
            byte_row(8'h34), byte_row(8'h12), byte_row(8'h07), byte_row(8'h00),
            byte_row(8'h01),
            byte_row(8'h00, 1'b1, frame_word(1'b0, 8'h00, 8'h07, 8'h00, 1'b1, 1'b1, 1'b0)),
            // first hunt byte pairs with a zero low byte
            reg_row(slpd_pkg::CFG_SYNC_CHECKED, 16'hFF00),
            reg_row(slpd_pkg::CFG_SYNC_UNCHECKED, 16'h0000),
            byte_row(8'hFF), byte_row(8'h3C), byte_row(8'h01), byte_row(8'h01),
            byte_row(8'h00), byte_row(8'h01),
            byte_row(8'h00), byte_row(8'h00),
            byte_row(8'h00, 1'b1, frame_word(1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1))
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG) begin
                write_reg(rows[i].idx, rows[i].value);
            end else begin
                push_word(rows[i].rx, rows[i].fixed, rows[i].want);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            chk_val   = 16'($urandom_range(0, 65535));
            plain_val = 16'($urandom_range(0, 65535));
            case (p)
                0: begin
                    chk_val   = slpd_pkg::SYNC_CHECKED_RESET;
                    plain_val = slpd_pkg::SYNC_UNCHECKED_RESET;
                end
                1: begin
                    chk_val   = 16'hFFFF;
                    plain_val = 16'h0000;
                end
                3: begin
                    chk_val   = 16'h5A5A;
                    plain_val = 16'h5A5A;
                end
                4: begin
                    chk_val   = 16'h0000;
                    plain_val = 16'hFFFF;
                end
                default: ;
            endcase
            write_reg(slpd_pkg::CFG_SYNC_CHECKED, chk_val);
            write_reg(slpd_pkg::CFG_SYNC_UNCHECKED, plain_val);
            target = n_sent + WORDS_PER_PHASE;
            while (n_sent < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 6)) push_word(8'($urandom_range(0, 255)));
                    continue;
                end
                sw = ($urandom_range(0, 1) == 1) ? sync_chk : sync_plain;
                push_word(sw[7:0]);
                if (ph != GET_TYPE) push_word(sw[15:8]);
                if (ph != GET_TYPE) continue;
                push_word(8'($urandom_range(0, 255)));
                pick = $urandom_range(0, 99);
                if (pick < 1) begin
                    len = 255;
                end else if (pick < 8) begin
                    len = 0;
                end else if (pick < 12) begin
                    len = $urandom_range(13, 64);
                end else begin
                    len = $urandom_range(1, 12);
                end
                push_word(len[7:0]);
                pay.delete();
                csum = '0;
                for (int i = 0; i < len; i++) begin
                    pay.push_back(8'($urandom_range(0, 255)));
                    csum = csum + {8'h00, pay[i]};
                end
                if (chk_mode) begin
                    if ($urandom_range(0, 3) == 0) csum = 16'($urandom_range(0, 65535));
                    push_word(csum[7:0]);
                    push_word(csum[15:8]);
                end
                foreach (pay[i]) push_word(pay[i]);
            end
        end

        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (4 * DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
